// ===== rtl/tpag_pkg.sv =====
// Shared constants for the tensor permute address generator.
package tpag_pkg;

	localparam int MAX_RANK_DEF   = 5;
	localparam int SIZE_BITS_DEF  = 16;
	localparam int INDEX_BITS_DEF = 32;

	localparam int RANK_BITS       = 3;
	localparam int PERM_ENTRY_BITS = 3;

	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	localparam int REG_RANK      = 0;
	localparam int REG_SIZE_BASE = 1;

endpackage

// ===== rtl/tpag_fifo.sv =====
// Small register-based FIFO used between the generator stages.
module tpag_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [WIDTH-1:0]             wdata,
	input  logic                         rd_en,
	output logic [WIDTH-1:0]             rdata,
	output logic                         full,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

// ===== rtl/tpag_cfg.sv =====
// Configuration registers, effective extents and stride recurrence.
module tpag_cfg #(
	parameter int MAX_RANK   = tpag_pkg::MAX_RANK_DEF,
	parameter int SIZE_BITS  = tpag_pkg::SIZE_BITS_DEF,
	parameter int INDEX_BITS = tpag_pkg::INDEX_BITS_DEF,
	parameter int CFG_IDX_W  = 3,
	parameter int CFG_DATA_W = 16
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              wr_en,
	input  logic [CFG_IDX_W-1:0]                              wr_index,
	input  logic [CFG_DATA_W-1:0]                             wr_data,
	output logic [tpag_pkg::RANK_BITS-1:0]                    eff_rank,
	output logic [MAX_RANK-1:0][SIZE_BITS-1:0]                eff_size,
	output logic [MAX_RANK-1:0][tpag_pkg::PERM_ENTRY_BITS-1:0] perm,
	output logic [MAX_RANK-1:0][INDEX_BITS-1:0]               stride,
	output logic                                              settling
);
	import tpag_pkg::*;

	localparam int SETTLE_W = $clog2(MAX_RANK + 1);

	logic [RANK_BITS-1:0]                          rank_q;
	logic [MAX_RANK-1:0][SIZE_BITS-1:0]            size_q;
	logic [MAX_RANK-1:0][PERM_ENTRY_BITS-1:0]      perm_q;
	logic [MAX_RANK-1:0][INDEX_BITS-1:0]           stride_q;
	logic [SETTLE_W-1:0]                           settle_q;
	logic [INDEX_BITS+SIZE_BITS-1:0]               stride_prod [MAX_RANK];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q   <= RANK_BITS'(1);
			settle_q <= '0;
			for (int d = 0; d < MAX_RANK; d++) begin
				size_q[d] <= SIZE_BITS'(1);
				perm_q[d] <= PERM_ENTRY_BITS'(d);
			end
		end else begin
			if (wr_en) begin
				settle_q <= SETTLE_W'(MAX_RANK);
				if (wr_index == CFG_IDX_W'(REG_RANK)) begin
					rank_q <= wr_data[RANK_BITS-1:0];
				end
				for (int d = 0; d < MAX_RANK; d++) begin
					if (wr_index == CFG_IDX_W'(REG_SIZE_BASE + d)) begin
						size_q[d] <= wr_data[SIZE_BITS-1:0];
					end
				end
				if (wr_index == CFG_IDX_W'(REG_SIZE_BASE + MAX_RANK)) begin
					perm_q <= wr_data[MAX_RANK*PERM_ENTRY_BITS-1:0];
				end
			end else if (settle_q != '0) begin
				settle_q <= settle_q - SETTLE_W'(1);
			end
		end
	end

	always_comb begin
		if (rank_q == '0) begin
			eff_rank = RANK_BITS'(1);
		end else if (int'(rank_q) > MAX_RANK) begin
			eff_rank = RANK_BITS'(MAX_RANK);
		end else begin
			eff_rank = rank_q;
		end
		for (int d = 0; d < MAX_RANK; d++) begin
			eff_size[d] = (size_q[d] == '0) ? SIZE_BITS'(1) : size_q[d];
		end
	end

	always_comb begin
		for (int d = 0; d < MAX_RANK; d++) begin
			if (d + 1 < MAX_RANK) begin
				stride_prod[d] = stride_q[(d+1) % MAX_RANK] * eff_size[(d+1) % MAX_RANK];
			end else begin
				stride_prod[d] = (INDEX_BITS+SIZE_BITS)'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAX_RANK; d++) begin
				stride_q[d] <= INDEX_BITS'(1);
			end
		end else begin
			for (int d = 0; d < MAX_RANK; d++) begin
				if (d + 1 >= int'(eff_rank)) begin
					stride_q[d] <= INDEX_BITS'(1);
				end else begin
					stride_q[d] <= stride_prod[d][INDEX_BITS-1:0];
				end
			end
		end
	end

	assign perm     = perm_q;
	assign stride   = stride_q;
	assign settling = (settle_q != '0);

endmodule

// ===== rtl/tpag_front.sv =====
// Front end: accepts step requests and advances the permuted odometer.
module tpag_front #(
	parameter int MAX_RANK   = tpag_pkg::MAX_RANK_DEF,
	parameter int SIZE_BITS  = tpag_pkg::SIZE_BITS_DEF,
	parameter int INDEX_BITS = tpag_pkg::INDEX_BITS_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               accept,
	input  logic                                               restart,
	input  logic [tpag_pkg::RANK_BITS-1:0]                     eff_rank,
	input  logic [MAX_RANK-1:0][SIZE_BITS-1:0]                 eff_size,
	input  logic [MAX_RANK-1:0][tpag_pkg::PERM_ENTRY_BITS-1:0] perm,
	output logic [MAX_RANK-1:0][SIZE_BITS-1:0]                 coord,
	output logic [INDEX_BITS-1:0]                              count,
	output logic                                               last
);
	import tpag_pkg::*;

	localparam int DIM_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

	logic [MAX_RANK-1:0][SIZE_BITS-1:0] coord_q;
	logic [INDEX_BITS-1:0]              count_q;
	logic [MAX_RANK-1:0][SIZE_BITS-1:0] coord_nxt;
	logic                               carry;

	assign coord = restart ? '0 : coord_q;
	assign count = restart ? '0 : count_q;
	assign last  = carry;

	always_comb begin
		logic [PERM_ENTRY_BITS-1:0] pd;
		logic [DIM_W-1:0]           idx;
		coord_nxt = coord;
		carry     = 1'b1;
		pd        = '0;
		idx       = '0;
		for (int k = MAX_RANK - 1; k >= 0; k--) begin
			pd  = perm[k];
			idx = pd[DIM_W-1:0];
			if (carry && (k < int'(eff_rank)) && (pd < eff_rank)) begin
				if (({1'b0, coord_nxt[idx]} + (SIZE_BITS+1)'(1)) >= {1'b0, eff_size[idx]}) begin
					coord_nxt[idx] = '0;
				end else begin
					coord_nxt[idx] = coord_nxt[idx] + SIZE_BITS'(1);
					carry          = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			coord_q <= coord_nxt;
			count_q <= carry ? '0 : count + INDEX_BITS'(1);
		end
	end

endmodule

// ===== rtl/tpag_back.sv =====
// Back end: dot product of coordinate and strides into the source index.
module tpag_back #(
	parameter int MAX_RANK   = tpag_pkg::MAX_RANK_DEF,
	parameter int SIZE_BITS  = tpag_pkg::SIZE_BITS_DEF,
	parameter int INDEX_BITS = tpag_pkg::INDEX_BITS_DEF,
	parameter int OUT_DEPTH  = tpag_pkg::OUT_DEPTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   mid_empty,
	input  logic [MAX_RANK-1:0][SIZE_BITS-1:0]     mid_coord,
	input  logic [INDEX_BITS-1:0]                  mid_count,
	input  logic                                   mid_last,
	output logic                                   mid_pop,
	input  logic [tpag_pkg::RANK_BITS-1:0]         eff_rank,
	input  logic [MAX_RANK-1:0][INDEX_BITS-1:0]    stride,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]         out_count,
	output logic                                   out_push,
	output logic [INDEX_BITS-1:0]                  out_source,
	output logic [INDEX_BITS-1:0]                  out_dest,
	output logic                                   out_last
);
	import tpag_pkg::*;

	logic [MAX_RANK-1:0][INDEX_BITS-1:0] prod_s1;
	logic [INDEX_BITS-1:0]               count_s1;
	logic                                last_s1;
	logic                                valid_s1;
	logic [INDEX_BITS-1:0]               src_s2;
	logic [INDEX_BITS-1:0]               count_s2;
	logic                                last_s2;
	logic                                valid_s2;

	logic [INDEX_BITS+SIZE_BITS-1:0]     prod_full [MAX_RANK];
	logic [INDEX_BITS-1:0]               sum_c;

	assign mid_pop = !mid_empty &&
		((int'(out_count) + int'(valid_s1) + int'(valid_s2)) < OUT_DEPTH);

	always_comb begin
		for (int d = 0; d < MAX_RANK; d++) begin
			if (d < int'(eff_rank)) begin
				prod_full[d] = mid_coord[d] * stride[d];
			end else begin
				prod_full[d] = '0;
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int d = 0; d < MAX_RANK; d++) begin
			sum_c = sum_c + prod_s1[d];
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			for (int d = 0; d < MAX_RANK; d++) begin
				prod_s1[d] <= prod_full[d][INDEX_BITS-1:0];
			end
			count_s1 <= mid_count;
			last_s1  <= mid_last;
		end
		if (valid_s1) begin
			src_s2   <= sum_c;
			count_s2 <= count_s1;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= mid_pop;
			valid_s2 <= valid_s1;
		end
	end

	assign out_push   = valid_s2;
	assign out_source = src_s2;
	assign out_dest   = count_s2;
	assign out_last   = last_s2;

endmodule

// ===== rtl/tensor_permute_address_gen.sv =====
// Top level of the tensor permute address generator.
//
// Usage: each transaction pushed on the input queue (push/full) carries a
// restart flag and asks for the next element of a permuted tensor copy.
// Every transaction yields one result on the output queue (empty/pop):
// source_index, dest_index and last. Results come out in request order.
// From an accepted push to empty falling, the odometer steps into the middle
// queue at the accepting edge, then dequeue with stride multiply, adder tree
// and result queue write follow in order. One request is accepted per cycle
// while full is low; the odometer next state is computed combinationally from
// its registers and the multiply/add pipeline keeps pace.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken
// every cycle; after a write full stays high while the stride registers
// recompute.
// Reset clears the coordinate and the element count, loads rank 1, all
// extents 1 and the identity permutation, and empties both queues.
// When the receiver stalls, results collect in a four-entry queue; the back
// end stops issuing on credit, the two-entry middle queue fills and full
// rises, holding off new requests without losing any.
module tensor_permute_address_gen #(
	parameter int MAX_RANK   = tpag_pkg::MAX_RANK_DEF,
	parameter int SIZE_BITS  = tpag_pkg::SIZE_BITS_DEF,
	parameter int INDEX_BITS = tpag_pkg::INDEX_BITS_DEF,
	parameter int CFG_IDX_W  = $clog2(MAX_RANK + 2),
	parameter int CFG_DATA_W = (SIZE_BITS > 3 * MAX_RANK) ? SIZE_BITS : 3 * MAX_RANK
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic                   restart,
	output logic                   empty,
	input  logic                   pop,
	output logic [INDEX_BITS-1:0]  source_index,
	output logic [INDEX_BITS-1:0]  dest_index,
	output logic                   last,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);
	import tpag_pkg::*;

	localparam int COORD_W = MAX_RANK * SIZE_BITS;
	localparam int MID_W   = COORD_W + INDEX_BITS + 1;
	localparam int OUT_W   = 2 * INDEX_BITS + 1;

	logic [RANK_BITS-1:0]                     eff_rank;
	logic [MAX_RANK-1:0][SIZE_BITS-1:0]       eff_size;
	logic [MAX_RANK-1:0][PERM_ENTRY_BITS-1:0] perm;
	logic [MAX_RANK-1:0][INDEX_BITS-1:0]      stride;
	logic                                     settling;

	logic                                     accept;
	logic [MAX_RANK-1:0][SIZE_BITS-1:0]       f_coord;
	logic [INDEX_BITS-1:0]                    f_count;
	logic                                     f_last;

	logic [MID_W-1:0]                         mid_rdata;
	logic                                     mid_full;
	logic                                     mid_empty;
	logic                                     mid_pop;
	logic [$clog2(MID_DEPTH+1)-1:0]           mid_count;

	logic                                     out_push;
	logic [INDEX_BITS-1:0]                    out_source;
	logic [INDEX_BITS-1:0]                    out_dest;
	logic                                     out_last;
	logic [OUT_W-1:0]                         out_rdata;
	logic                                     out_full;
	logic                                     out_empty;
	logic [$clog2(OUT_DEPTH+1)-1:0]           out_count;

	assign cfg_ready = 1'b1;
	assign full      = mid_full || settling;
	assign accept    = push && !full;

	tpag_cfg #(
		.MAX_RANK   (MAX_RANK),
		.SIZE_BITS  (SIZE_BITS),
		.INDEX_BITS (INDEX_BITS),
		.CFG_IDX_W  (CFG_IDX_W),
		.CFG_DATA_W (CFG_DATA_W)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.eff_rank (eff_rank),
		.eff_size (eff_size),
		.perm     (perm),
		.stride   (stride),
		.settling (settling)
	);

	tpag_front #(
		.MAX_RANK   (MAX_RANK),
		.SIZE_BITS  (SIZE_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.restart  (restart),
		.eff_rank (eff_rank),
		.eff_size (eff_size),
		.perm     (perm),
		.coord    (f_coord),
		.count    (f_count),
		.last     (f_last)
	);

	tpag_fifo #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wdata  ({f_coord, f_count, f_last}),
		.rd_en  (mid_pop),
		.rdata  (mid_rdata),
		.full   (mid_full),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	tpag_back #(
		.MAX_RANK   (MAX_RANK),
		.SIZE_BITS  (SIZE_BITS),
		.INDEX_BITS (INDEX_BITS),
		.OUT_DEPTH  (OUT_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mid_empty  (mid_empty),
		.mid_coord  (mid_rdata[MID_W-1 -: COORD_W]),
		.mid_count  (mid_rdata[INDEX_BITS:1]),
		.mid_last   (mid_rdata[0]),
		.mid_pop    (mid_pop),
		.eff_rank   (eff_rank),
		.stride     (stride),
		.out_count  (out_count),
		.out_push   (out_push),
		.out_source (out_source),
		.out_dest   (out_dest),
		.out_last   (out_last)
	);

	tpag_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (out_push),
		.wdata  ({out_source, out_dest, out_last}),
		.rd_en  (pop && !out_empty),
		.rdata  (out_rdata),
		.full   (out_full),
		.empty  (out_empty),
		.count  (out_count)
	);

	assign empty        = out_empty || (mid_count > $bits(mid_count)'(MID_DEPTH)) ||
		(out_full && !out_full);
	assign source_index = out_rdata[OUT_W-1 -: INDEX_BITS];
	assign dest_index   = out_rdata[INDEX_BITS:1];
	assign last         = out_rdata[0];

endmodule
